// ----- rtl/skgs_pkg.sv -----
// Shared types and widths for the sorted key group sum block.
`default_nettype none

package skgs_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 38;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 2;

  typedef logic        [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // One buffer entry: record key, raw value and running (later: group) sum
  typedef struct packed {
    key_t key;
    val_t value;
    sum_t sum;
  } entry_t;

  // Batch-end notice from the loader to the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } batch_t;

endpackage : skgs_pkg

`default_nettype wire

// ----- rtl/sorted_key_group_sum_core.sv -----
// Top level of the sorted key group sum block.
`default_nettype none

// Takes a batch of key-sorted records, one beat per cycle, and stores up to DEPTH of
// them with the running sum of each run of equal keys; records past DEPTH are
// dropped and the batch is marked as overflowed. The beat with tlast closes the
// batch: input ready then stays low while the block walks the buffer backward to
// write each run's total over its running sums, and then emits the stored records in
// arrival order, one beat per cycle while the output is taken, with tlast on the
// last one. Both passes are paced by the single read port of the record buffer,
// and the next batch is taken only once both passes are through. The last result may
// still wait in the output register while loading resumes.
module sorted_key_group_sum_core #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // record_key[31:0], record_value[63:32]
  input  logic          s_axis_tlast,   // batch_end
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // out_key[31:0], out_value[63:32],
                                        // group_total[101:64], zero pad
  output logic [1:0]    m_axis_tuser,   // group_start[0], overflow_seen[1]
  output logic          m_axis_tlast    // final_result
);
  import skgs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          load_en;
  logic          ld_we;
  logic [AW-1:0] ld_addr;
  entry_t        ld_data;
  batch_t        batch;
  logic [CW-1:0] batch_n;

  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic          bk_we;
  logic [AW-1:0] bk_addr;
  sum_t          bk_sum;

  logic          we_sum;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  skgs_loader #(.DEPTH(DEPTH)) u_loader (
    .clk           (clk),
    .rst           (rst),
    .load_en       (load_en),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .we            (ld_we),
    .waddr         (ld_addr),
    .wdata         (ld_data),
    .batch         (batch),
    .batch_n       (batch_n)
  );

  // Write port shared by loading and the backward pass (never both at once)
  always_comb begin
    we_sum      = ld_we || bk_we;
    waddr       = ld_we ? ld_addr : bk_addr;
    wdata.key   = ld_data.key;
    wdata.value = ld_data.value;
    wdata.sum   = ld_we ? ld_data.sum : bk_sum;
  end

  skgs_buffer #(.DEPTH(DEPTH)) u_buffer (
    .clk    (clk),
    .we_kv  (ld_we),
    .we_sum (we_sum),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  skgs_seq #(.DEPTH(DEPTH)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .batch         (batch),
    .batch_n       (batch_n),
    .load_en       (load_en),
    .re            (re),
    .raddr         (raddr),
    .rdata         (rdata),
    .bk_we         (bk_we),
    .bk_addr       (bk_addr),
    .bk_sum        (bk_sum),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule : sorted_key_group_sum_core

`default_nettype wire

// ----- rtl/skgs_buffer.sv -----
// Record buffer: key, value and sum memories, one write port, one registered read port.
`default_nettype none

module skgs_buffer #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we_kv,
  input  logic             we_sum,
  input  logic [AW-1:0]    waddr,
  input  skgs_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output skgs_pkg::entry_t rdata
);
  import skgs_pkg::*;

  key_t key_mem   [DEPTH];
  val_t value_mem [DEPTH];
  sum_t sum_mem   [DEPTH];

  // Write port: key/value only on load, sum on load and on the back pass
  always_ff @(posedge clk) begin
    if (we_kv) begin
      key_mem[waddr]   <= wdata.key;
      value_mem[waddr] <= wdata.value;
    end
    if (we_sum) begin
      sum_mem[waddr] <= wdata.sum;
    end
  end

  // Read port: data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata.key   <= key_mem[raddr];
      rdata.value <= value_mem[raddr];
      rdata.sum   <= sum_mem[raddr];
    end
  end

endmodule : skgs_buffer

`default_nettype wire

// ----- rtl/skgs_loader.sv -----
// Input side: takes records, keeps the running sum per run of equal keys, fills the buffer.
`default_nettype none

module skgs_loader #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load_en,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [skgs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 we,
  output logic [AW-1:0]                        waddr,
  output skgs_pkg::entry_t                     wdata,
  output skgs_pkg::batch_t                     batch,
  output logic [CW-1:0]                        batch_n
);
  import skgs_pkg::*;

  logic [CW-1:0] count;
  key_t          prev_key;
  sum_t          gsum;
  logic          ovf;

  key_t rec_key;
  val_t rec_value;
  logic accept;
  logic room;
  logic start;
  sum_t sum_next;

  assign rec_key       = s_axis_tdata[KEY_W-1:0];
  assign rec_value     = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
  assign s_axis_tready = load_en;

  // Run detection and running sum
  always_comb begin
    accept   = s_axis_tvalid && s_axis_tready;
    room     = (count != CW'(DEPTH));
    start    = (count == '0) || (rec_key != prev_key);
    sum_next = start ? SUM_W'(rec_value) : gsum + SUM_W'(rec_value);
  end

  // Buffer write and batch-end notice
  always_comb begin
    we          = accept && room;
    waddr       = count[AW-1:0];
    wdata.key   = rec_key;
    wdata.value = rec_value;
    wdata.sum   = sum_next;
    batch.done  = accept && s_axis_tlast;
    batch.ovf   = ovf || !room;
    batch_n     = room ? count + CW'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      prev_key <= '0;
      gsum     <= '0;
      ovf      <= 1'b0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        count    <= '0;
        prev_key <= '0;
        gsum     <= '0;
        ovf      <= 1'b0;
      end else if (room) begin
        count    <= count + CW'(1);
        prev_key <= rec_key;
        gsum     <= sum_next;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("record count beyond depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CW'(DEPTH)))
    else $error("overflow flagged with room left");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (count == '0 && !ovf))
    else $error("loader not cleared after batch end");

endmodule : skgs_loader

`default_nettype wire

// ----- rtl/skgs_seq.sv -----
// Batch-end sequencer: backward pass writing group totals, then forward emission.
`default_nettype none

module skgs_seq #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  skgs_pkg::batch_t                  batch,
  input  logic [CW-1:0]                     batch_n,
  output logic                              load_en,
  output logic                              re,
  output logic [AW-1:0]                     raddr,
  input  skgs_pkg::entry_t                  rdata,
  output logic                              bk_we,
  output logic [AW-1:0]                     bk_addr,
  output skgs_pkg::sum_t                    bk_sum,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [skgs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [skgs_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);
  import skgs_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_BACK, S_EMIT} state_t;

  state_t        state;
  logic [CW-1:0] n_reg;
  logic          ovf_reg;
  logic [CW-1:0] cnt;      // back: reads left; emit: next index to read
  logic          dv;       // read data valid this cycle
  logic [AW-1:0] dv_idx;   // index of the data in rdata
  sum_t          tot_reg;  // total of the run being walked backward
  key_t          nkey;     // back: key of next entry; emit: previous emitted key

  logic [CW-1:0] n_m1;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx;
  logic          move;
  logic          bk_first;
  logic          grp_start;

  always_comb begin
    n_m1     = n_reg - CW'(1);
    cnt_m1   = cnt - CW'(1);
    last_idx = n_m1[AW-1:0];
    load_en  = (state == S_LOAD);
    move     = (state == S_EMIT) && dv && (!m_axis_tvalid || m_axis_tready);
  end

  // Read issue for both passes
  always_comb begin
    re    = 1'b0;
    raddr = cnt[AW-1:0];
    unique case (state)
      S_BACK: begin
        re    = (cnt != '0);
        raddr = cnt_m1[AW-1:0];
      end
      S_EMIT: begin
        re    = (cnt != n_reg) && (!dv || move);
        raddr = cnt[AW-1:0];
      end
      S_LOAD: begin
        re = 1'b0;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // Backward pass: a run's total is the running sum at its last record
  always_comb begin
    bk_first  = (dv_idx == last_idx);
    bk_we     = (state == S_BACK) && dv;
    bk_addr   = dv_idx;
    bk_sum    = (bk_first || rdata.key != nkey) ? rdata.sum : tot_reg;
    grp_start = (dv_idx == '0) || (rdata.key != nkey);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      cnt           <= '0;
      dv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (re) begin
        dv_idx <= raddr;
      end

      // Output register
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (move) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {{(OUT_TDATA_W-KEY_W-VAL_W-SUM_W){1'b0}},
                          rdata.sum, rdata.value, rdata.key};
        m_axis_tuser  <= {ovf_reg, grp_start};
        m_axis_tlast  <= (dv_idx == last_idx);
      end

      unique case (state)
        S_LOAD: begin
          dv <= 1'b0;
          if (batch.done) begin
            n_reg   <= batch_n;
            ovf_reg <= batch.ovf;
            cnt     <= batch_n;
            state   <= S_BACK;
          end
        end
        S_BACK: begin
          dv <= re;
          if (re) begin
            cnt <= cnt_m1;
          end
          if (dv) begin
            tot_reg <= bk_sum;
            nkey    <= rdata.key;
            if (dv_idx == '0) begin
              cnt   <= '0;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (re) begin
            cnt <= cnt + CW'(1);
            dv  <= 1'b1;
          end else if (move) begin
            dv <= 1'b0;
          end
          if (move) begin
            nkey <= rdata.key;
            if (dv_idx == last_idx) begin
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_bk_no_collide: assert property (@(posedge clk) disable iff (rst)
    (state == S_BACK && dv && re) |-> (raddr != dv_idx))
    else $error("back pass read and write hit the same entry");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && dv) |-> (dv_idx <= last_idx))
    else $error("emission index past batch size");

  a_final_return: assert property (@(posedge clk) disable iff (rst)
    (move && dv_idx == last_idx) |=> (state == S_LOAD && m_axis_tvalid && m_axis_tlast))
    else $error("final beat not flagged or load not resumed");

endmodule : skgs_seq

`default_nettype wire

// ----- tb/sorted_key_group_sum_core_tb.sv -----
// Self-checking testbench for the sorted key group sum core.
`timescale 1ns / 1ps

module sorted_key_group_sum_core_tb;
  import skgs_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 2 * DEPTH + 8;

  typedef enum logic {RX_OPEN, RX_CHOPPY} rx_mode_t;

  // One emitted record as the block should present it
  typedef struct packed {
    key_t key;
    val_t value;
    sum_t total;
    logic start;
    logic ovf;
    logic final_row;
  } group_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  // Golden copy of the block state
  key_t        held_key [DEPTH];
  val_t        held_val [DEPTH];
  sum_t        held_run [DEPTH];
  int unsigned held_count;
  key_t        last_key;
  sum_t        run_sum;
  bit          dropped;

  group_row_t  pending_rows [$];
  int unsigned mismatch_count;
  int unsigned rows_seen;
  int unsigned quiet_cycles;

  // Sender burst and receiver stall control
  bit          tx_steady;
  int unsigned tx_burst_left;
  rx_mode_t    rx_mode = RX_OPEN;
  bit          rx_on;
  int unsigned rx_left;

  sorted_key_group_sum_core #(.DEPTH(DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // record_key[31:0], record_value[63:32]
    .s_axis_tlast  (s_axis_tlast),   // batch_end
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_key, out_value, group_total, zero pad
    .m_axis_tuser  (m_axis_tuser),   // group_start[0], overflow_seen[1]
    .m_axis_tlast  (m_axis_tlast)    // final_result
  );

  always #4 clk = ~clk;

  // Store one record, and on batch end queue every stored record with its run total
  function automatic void predict_group_sums(key_t k, val_t v, bit batch_end);
    sum_t        totals [DEPTH];
    sum_t        total;
    group_row_t  row;
    int          i;
    if (held_count < DEPTH) begin
      if (held_count == 0 || k != last_key) begin
        run_sum = sum_t'(v);
      end else begin
        run_sum = run_sum + sum_t'(v);
      end
      held_key[held_count] = k;
      held_val[held_count] = v;
      held_run[held_count] = run_sum;
      last_key = k;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!batch_end) return;

    // backward walk: a run's total is the running sum at its last record
    total = '0;
    for (i = held_count - 1; i >= 0; i--) begin
      if (i == held_count - 1 || held_key[i] != held_key[i+1]) total = held_run[i];
      totals[i] = total;
    end
    for (i = 0; i < held_count; i++) begin
      row.key       = held_key[i];
      row.value     = held_val[i];
      row.total     = totals[i];
      row.start     = (i == 0) || (held_key[i] != held_key[i-1]);
      row.ovf       = dropped;
      row.final_row = (i == held_count - 1);
      pending_rows.push_back(row);
    end
    held_count = 0;
    last_key   = '0;
    run_sum    = '0;
    dropped    = 1'b0;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, int unsigned row, logic [63:0] want,
                                      logic [63:0] got);
    if (got !== want) begin
      note_mismatch($sformatf("row %0d %s expected %h got %h", row, name, want, got));
    end
  endfunction

  // Output checker: every beat taken is compared with the oldest pending row
  always @(posedge clk) begin : check_out
    group_row_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_rows.size() == 0) begin
        note_mismatch($sformatf("row %0d unexpected beat data %h", rows_seen, m_axis_tdata));
      end else begin
        want = pending_rows.pop_front();
        check_field("key", rows_seen, {want.key}, m_axis_tdata[31:0]);
        check_field("value", rows_seen, {want.value}, m_axis_tdata[63:32]);
        check_field("group_total", rows_seen, {want.total}, m_axis_tdata[101:64]);
        check_field("pad", rows_seen, '0, m_axis_tdata[103:102]);
        check_field("group_start", rows_seen, {want.start}, m_axis_tuser[0]);
        check_field("overflow_seen", rows_seen, {want.ovf}, m_axis_tuser[1]);
        check_field("final_result", rows_seen, {want.final_row}, m_axis_tlast);
      end
      rows_seen++;
    end
  end

  // Receiver: alternating runs of ready and stall of random length
  always @(posedge clk) begin
    if (rx_mode == RX_OPEN) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_on = !rx_on;
        if (rx_on) rx_left = $urandom_range(1, 8);
        else if ($urandom_range(0, 7) == 0) rx_left = $urandom_range(8, 20);
        else rx_left = $urandom_range(1, 4);
      end
      rx_left--;
      m_axis_tready <= rx_on;
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one record; valid stays high afterward so bursts run back to back
  task automatic send_record(key_t k, val_t v, bit batch_end);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      gap = tx_steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 16);
    end
    tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tlast  <= batch_end;
    do @(posedge clk); while (!s_axis_tready);
    predict_group_sums(k, v, batch_end);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(0, 5))
      0:       return val_t'(32'h7FFF_FFFF);
      1:       return val_t'(32'h8000_0000);
      2:       return val_t'($urandom_range(0, 32'h20000) - 32'h10000);
      default: return val_t'($urandom);
    endcase
  endfunction

  // Batch of random content; sorted runs unless shuffled, which reuses a few keys
  task automatic send_batch(int unsigned count, bit shuffled);
    longint unsigned k;
    int unsigned     i;
    case ($urandom_range(0, 3))
      0:       k = 0;
      1:       k = $urandom;
      2:       k = 32'hFFFF_FF00 + $urandom_range(0, 255);
      default: k = $urandom_range(0, 255);
    endcase
    for (i = 0; i < count; i++) begin
      if (i > 0) begin
        if (shuffled) begin
          case ($urandom_range(0, 3))
            0:       k = 0;
            1:       k = 7;
            2:       k = 32'h8000_0000;
            default: k = 32'hFFFF_FFFF;
          endcase
        end else if ($urandom_range(0, 99) >= 45) begin
          k = k + (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 16));
          if (k > 32'hFFFF_FFFF) k = 32'hFFFF_FFFF;
        end
      end
      send_record(key_t'(k), pick_value(), i == count - 1);
    end
  endtask

  task automatic send_run(int unsigned count, key_t k, val_t v);
    int unsigned i;
    for (i = 0; i < count; i++) send_record(k, v, i == count - 1);
  endtask

  // Batches of one record at key and value extremes; key zero matches the cleared state
  task automatic test_single_records();
    tx_steady = 1'b1;
    rx_mode  <= RX_OPEN;
    send_record(32'h0000_0000, val_t'(32'h7FFF_FFFF), 1'b1);
    send_record(32'hFFFF_FFFF, val_t'(32'h8000_0000), 1'b1);
  endtask

  // Several runs of equal keys with mixed signs
  task automatic test_group_runs();
    tx_steady = 1'b0;
    rx_mode  <= RX_CHOPPY;
    send_record(32'h0000_0001, val_t'(32'h0001_8000), 1'b0);
    send_record(32'h0000_0001, val_t'(32'hFFFF_FFFF), 1'b0);
    send_record(32'h0000_0002, val_t'(32'h0000_0000), 1'b0);
    send_record(32'h0000_0002, val_t'(32'h7FFF_FFFF), 1'b0);
    send_record(32'h0000_0002, val_t'(32'h7FFF_FFFF), 1'b0);
    send_record(32'h5555_AAAA, val_t'(32'h8000_0000), 1'b0);
    send_record(32'hFFFF_FFFF, val_t'(32'hFFFE_0000), 1'b1);
  endtask

  // Unsorted input: a key that comes back later opens a new group
  task automatic test_key_reappears();
    send_record(32'h0000_0003, val_t'(32'h0000_0010), 1'b0);
    send_record(32'h0000_0009, val_t'(32'hFFFF_FFF0), 1'b0);
    send_record(32'h0000_0009, val_t'(32'h0000_0001), 1'b0);
    send_record(32'h0000_0003, val_t'(32'h0001_0000), 1'b0);
    send_record(32'h0000_0003, val_t'(32'h0002_0000), 1'b1);
  endtask

  task automatic test_negative_sum();
    send_run(4, 32'hFFFF_FFFF, val_t'(32'h8000_0000));
  endtask

  // Exactly full store: most negative possible group total, no overflow
  task automatic test_capacity_full();
    tx_steady = 1'b1;
    rx_mode  <= RX_OPEN;
    send_run(DEPTH, 32'h0000_1234, val_t'(32'h8000_0000));
  endtask

  // Past capacity: the batch end lands on a dropped record
  task automatic test_capacity_overflow();
    tx_steady = 1'b0;
    rx_mode  <= RX_CHOPPY;
    send_run(DEPTH + 2, 32'hCAFE_0001, val_t'(32'h7FFF_FFFF));
    send_batch(DEPTH + $urandom_range(1, 4), 1'b0);
  endtask

  // Sender holds off until every queued row has been taken
  task automatic test_drain_pause();
    send_batch(5, 1'b0);
    wait_drained();
    send_batch(3, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_batches();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 35) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_mode  <= ($urandom_range(0, 3) == 0) ? RX_OPEN : RX_CHOPPY;
      send_batch(len, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) wait_drained();
      sent += len;
    end
  endtask

  initial begin
    held_count    = 0;
    last_key      = '0;
    run_sum       = '0;
    dropped       = 1'b0;
    tx_burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_records();
    test_group_runs();
    test_key_reappears();
    test_negative_sum();
    test_capacity_full();
    test_capacity_overflow();
    test_drain_pause();
    test_random_batches();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
